// ----- rtl/assert_macros.svh -----
// assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds every clock unless reset is active
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property holds every clock, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- rtl/cvmb_pkg.sv -----
// ----------------------------------------------------------------------------
// cvmb_pkg
// constants, types and tables for the camera view matrix builder
// ----------------------------------------------------------------------------
package cvmb_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic [2:0]         ops;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic [1:0]         row;
        logic [1:0]         col;
        logic               last;
    } t_rsp;

    function automatic logic signed [21:0] atan_lut(input logic [3:0] i);
        case (i)
            4'd0:    atan_lut = 22'sd131072;
            4'd1:    atan_lut = 22'sd77376;
            4'd2:    atan_lut = 22'sd40884;
            4'd3:    atan_lut = 22'sd20753;
            4'd4:    atan_lut = 22'sd10417;
            4'd5:    atan_lut = 22'sd5213;
            4'd6:    atan_lut = 22'sd2607;
            4'd7:    atan_lut = 22'sd1304;
            4'd8:    atan_lut = 22'sd652;
            4'd9:    atan_lut = 22'sd326;
            4'd10:   atan_lut = 22'sd163;
            4'd11:   atan_lut = 22'sd81;
            4'd12:   atan_lut = 22'sd41;
            4'd13:   atan_lut = 22'sd20;
            4'd14:   atan_lut = 22'sd10;
            default: atan_lut = 22'sd5;
        endcase
    endfunction

endpackage

// ----- rtl/cvmb_if.sv -----
// ----------------------------------------------------------------------------
// cvmb_if
// valid/ready channel carrying one payload type
// ----------------------------------------------------------------------------
interface cvmb_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/camera_view_matrix_builder.sv -----
// sequence: accept, apply identity and translation, then emit the elements
//   rotation first runs two cordic passes, the coefficient products and the
//   multiply-accumulate (3 products plus write-back per element)
// flow control: one request at a time; no new request is accepted until all
//   sixteen elements have been emitted
// reset: synchronous active low, matrix returns to identity
// ----------------------------------------------------------------------------
// camera_view_matrix_builder
// view matrix kept in fixed point, updated by identity, translation and
// a pitch/yaw rotation through one shared multiplier and one cordic stage
// ----------------------------------------------------------------------------
module camera_view_matrix_builder
    import cvmb_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cvmb_if.sink   i_req,
    cvmb_if.source o_rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OPS  = 4'd1;
    localparam logic [3:0] S_CORA = 4'd2;
    localparam logic [3:0] S_CORB = 4'd3;
    localparam logic [3:0] S_COEF = 4'd4;
    localparam logic [3:0] S_MAC  = 4'd5;
    localparam logic [3:0] S_WB   = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;
    localparam logic [15:0] AMASK = 16'(16'hFFFF << (16 - ANGLE_BITS));
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic [3:0]         r_state;
    t_req               r_req;
    logic signed [31:0] r_m [16];
    logic signed [31:0] r_t [12];

    // cordic
    logic signed [33:0] r_x, r_y;
    logic signed [21:0] r_z;
    logic               r_neg;
    logic [4:0]         r_step;
    logic signed [16:0] r_sa, r_ca, r_sb, r_cb;
    logic signed [16:0] r_c [9];

    // mac counters
    logic [1:0] r_i, r_j, r_k;
    logic [3:0] r_cnt;
    logic signed [51:0] r_acc;
    logic signed [48:0] r_prod;
    logic               r_pv;

    // cordic step
    logic signed [33:0] sh_x, sh_y;
    logic signed [35:0] rx, ry;
    logic signed [16:0] cos_q, sin_q;
    assign sh_x = r_x >>> r_step[3:0];
    assign sh_y = r_y >>> r_step[3:0];
    assign rx = (r_neg ? -36'(r_x) : 36'(r_x)) + 36'sd16384;
    assign ry = (r_neg ? -36'(r_y) : 36'(r_y)) + 36'sd16384;

    function automatic logic signed [16:0] clampu(input logic signed [35:0] v);
        logic signed [35:0] q;
        q = v >>> 15;
        if (q > 36'sd32768) clampu = 17'sd32767 + 17'sd1;
        else if (q < -36'sd32768) clampu = -17'sd32768;
        else clampu = 17'(q);
    endfunction
    assign cos_q = clampu(rx);
    assign sin_q = clampu(ry);

    // fold angle into cordic start
    function automatic logic [22:0] fold(input logic [15:0] a);
        logic signed [17:0] z;
        logic               n;
        z = 18'(signed'({2'b00, a}));
        if (z >= 18'sd32768) z = z - 18'sd65536;
        n = 1'b0;
        if (z > 18'sd16384) begin
            z = z - 18'sd32768; n = 1'b1;
        end else if (z < -18'sd16384) begin
            z = z + 18'sd32768; n = 1'b1;
        end
        fold = {n, 22'(z) <<< 4};
    endfunction

    logic [15:0] ang_a, ang_b;
    logic [22:0] fa, fb;
    assign ang_a = r_req.angle_x & AMASK;
    assign ang_b = 16'(17'h10000 - {1'b0, r_req.angle_y & AMASK});
    assign fa = fold(ang_a);
    assign fb = fold(ang_b);

    // shared multiplier: 32 x 17
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    assign mul_p = 49'(mul_a) * 49'(mul_b);

    logic [3:0] coef_sel;
    always_comb begin
        mul_a = r_t[{r_k, r_j}];
        mul_b = r_c[4'(r_i) * 4'd3 + 4'(r_k)];
        coef_sel = r_cnt;
        if (r_state == S_COEF) begin
            case (coef_sel)
                4'd0:    begin mul_a = 32'(r_sa); mul_b = r_sb; end
                4'd1:    begin mul_a = 32'(r_sa); mul_b = r_cb; end
                4'd2:    begin mul_a = 32'(r_ca); mul_b = r_sb; end
                default: begin mul_a = 32'(r_ca); mul_b = r_cb; end
            endcase
        end
    end

    logic signed [48:0] rnd_p;
    assign rnd_p = (r_prod + 49'sd16384) >>> 15;
    // the third product is still in r_prod during write-back
    logic signed [51:0] rnd_acc;
    assign rnd_acc = (r_acc + 52'(r_prod) + 52'sd16384) >>> 15;
    logic signed [31:0] sat_acc;
    always_comb begin
        if (rnd_acc > 52'sd2147483647) sat_acc = 32'sh7FFFFFFF;
        else if (rnd_acc < -52'sd2147483648) sat_acc = 32'sh80000000;
        else sat_acc = 32'(rnd_acc);
    end

    function automatic logic signed [31:0] negsat(input logic signed [31:0] v);
        negsat = (v == 32'sh80000000) ? 32'sh7FFFFFFF : -v;
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data.element = r_m[r_cnt];
    assign o_rsp.data.row = r_cnt[3:2];
    assign o_rsp.data.col = r_cnt[1:0];
    assign o_rsp.data.last = (r_cnt == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            for (int n = 0; n < 16; n++)
                r_m[n] <= (n % 5 == 0) ? ONE : 32'sd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req   <= i_req.data;
                        r_state <= S_OPS;
                    end
                end
                S_OPS: begin
                    if (r_req.ops[0])
                        for (int n = 0; n < 16; n++)
                            r_m[n] <= (n % 5 == 0) ? ONE : 32'sd0;
                    if (r_req.ops[1]) begin
                        r_m[3]  <= negsat(r_req.pos_x);
                        r_m[7]  <= negsat(r_req.pos_y);
                        r_m[11] <= negsat(r_req.pos_z);
                    end
                    r_cnt <= '0;
                    if (r_req.ops[2]) begin
                        r_state <= S_CORA;
                        r_x <= CORDIC_X0; r_y <= '0;
                        r_z <= signed'(fa[21:0]); r_neg <= fa[22];
                        r_step <= '0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CORA, S_CORB: begin
                    if (r_step == 5'(CORDIC_STEPS)) begin
                        if (r_state == S_CORA) begin
                            r_sa <= sin_q; r_ca <= cos_q;
                            r_x <= CORDIC_X0; r_y <= '0;
                            r_z <= signed'(fb[21:0]); r_neg <= fb[22];
                            r_step <= '0;
                            r_state <= S_CORB;
                        end else begin
                            r_sb <= sin_q; r_cb <= cos_q;
                            r_cnt <= '0; r_pv <= 1'b0;
                            r_state <= S_COEF;
                        end
                    end else begin
                        if (r_z >= 0) begin
                            r_x <= r_x - sh_y; r_y <= r_y + sh_x;
                            r_z <= r_z - atan_lut(r_step[3:0]);
                        end else begin
                            r_x <= r_x + sh_y; r_y <= r_y - sh_x;
                            r_z <= r_z + atan_lut(r_step[3:0]);
                        end
                        r_step <= r_step + 5'd1;
                    end
                end
                S_COEF: begin
                    // one product per cycle, registered and rounded in the cycle after
                    r_prod <= mul_p;
                    r_pv   <= (r_cnt < 4'd4);
                    if (r_pv) begin
                        case (r_cnt)
                            4'd1:    r_c[3] <= -17'(rnd_p);
                            4'd2:    r_c[5] <= -17'(rnd_p);
                            4'd3:    r_c[6] <= 17'(rnd_p);
                            default: r_c[8] <= 17'(rnd_p);
                        endcase
                    end
                    if (r_cnt == 4'd4) begin
                        r_c[0] <= r_cb; r_c[1] <= '0; r_c[2] <= -r_sb;
                        r_c[4] <= r_ca; r_c[7] <= r_sa;
                        for (int n = 0; n < 12; n++) r_t[n] <= r_m[n];
                        r_i <= '0; r_j <= '0; r_k <= '0;
                        r_acc <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_MAC: begin
                    r_prod <= mul_p;
                    r_pv   <= 1'b1;
                    if (r_pv) r_acc <= r_acc + 52'(r_prod);
                    if (r_k == 2'd2) r_state <= S_WB;
                    else r_k <= r_k + 2'd1;
                end
                S_WB: begin
                    r_m[{r_i, r_j}] <= sat_acc;
                    r_acc <= '0; r_pv <= 1'b0; r_k <= '0;
                    if (r_j == 2'd3) begin
                        r_j <= '0;
                        if (r_i == 2'd2) begin
                            r_cnt <= '0; r_state <= S_OUT;
                        end else begin
                            r_i <= r_i + 2'd1; r_state <= S_MAC;
                        end
                    end else begin
                        r_j <= r_j + 2'd1; r_state <= S_MAC;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/cvmb_checker.sv -----
// ----------------------------------------------------------------------------
// cvmb_checker
// port-level checks on the camera view matrix builder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cvmb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_row,
    input logic [1:0]  rsp_col,
    input logic        rsp_last
);
    `ASSERT_CLK(a_no_overlap, i_clk, i_rst_n, !(req_ready && rsp_valid))
    `ASSERT_CLK(a_last_pos, i_clk, i_rst_n, rsp_valid |-> (rsp_last == (&{rsp_row, rsp_col})))
    `ASSERT_CLK(a_idle_after_last, i_clk, i_rst_n, (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
    `ASSERT_CLK(a_busy_after_req, i_clk, i_rst_n, (req_valid && req_ready) |=> !req_ready)
endmodule

bind camera_view_matrix_builder cvmb_checker u_cvmb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp_row   (o_rsp.data.row),
    .rsp_col   (o_rsp.data.col),
    .rsp_last  (o_rsp.data.last)
);

// ----- dv/camera_view_matrix_builder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_view_matrix_builder_tb
// drives identity, translation and rotation requests with random gaps and
// output stalls, predicts all sixteen matrix elements of each request and
// compares every emitted element in order
// ----------------------------------------------------------------------------
module camera_view_matrix_builder_tb;
    import cvmb_pkg::*;

    localparam logic [2:0] OP_IDENT = 3'b001;
    localparam logic [2:0] OP_TRANS = 3'b010;
    localparam logic [2:0] OP_ROT   = 3'b100;

    logic i_clk;
    logic i_rst_n;

    cvmb_if #(.T(t_req)) req_if ();
    cvmb_if #(.T(t_rsp)) rsp_if ();

    camera_view_matrix_builder uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    t_req   pending_reqs[$];
    t_rsp   expected_elems[$];
    longint view_m[16];
    int     errors;
    int     n_sent;
    int     n_checked;
    int     n_rot;
    bit     hold_off;
    int     burst_left;
    int     gap_left;
    int     stall_cnt;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_i32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd15(longint v);
        return asr(v + 16384, 15);
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 32768) return 32768;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                            652, 326, 163, 81, 41, 20, 10, 5};
        return tab[i];
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = ang;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= 32768) z -= 65536;
        if (z > 16384) begin
            z -= 32768;
            flip = 1;
        end else if (z < -16384) begin
            z += 32768;
            flip = 1;
        end
        z *= 16;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i);
                y  = y + asr(x, i);
                z -= atan_step(i);
            end else begin
                nx = x + asr(y, i);
                y  = y - asr(x, i);
                z += atan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_one(rnd15(x));
        s = clamp_one(rnd15(y));
    endtask

    function automatic void load_ident();
        for (int i = 0; i < 16; i++) view_m[i] = (i % 5 == 0) ? (64'sd1 << 16) : 0;
    endfunction

    task automatic predict_matrix(input t_req r);
        longint sa, ca, sb, cb, acc;
        longint rm[3][3];
        longint old_m[16];
        logic [15:0] yaw;
        t_rsp e;
        if (r.ops & OP_IDENT) load_ident();
        if (r.ops & OP_TRANS) begin
            view_m[3]  = sat_i32(-longint'(r.pos_x));
            view_m[7]  = sat_i32(-longint'(r.pos_y));
            view_m[11] = sat_i32(-longint'(r.pos_z));
        end
        if (r.ops & OP_ROT) begin
            yaw = 16'(17'h10000 - r.angle_y);
            sin_cos(r.angle_x, sa, ca);
            sin_cos(yaw, sb, cb);
            rm[0][0] = cb;               rm[0][1] = 0;  rm[0][2] = -sb;
            rm[1][0] = -rnd15(sa * sb);  rm[1][1] = ca; rm[1][2] = -rnd15(sa * cb);
            rm[2][0] = rnd15(ca * sb);   rm[2][1] = sa; rm[2][2] = rnd15(ca * cb);
            old_m = view_m;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 4; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) acc += rm[i][k] * old_m[k * 4 + j];
                    view_m[i * 4 + j] = sat_i32(rnd15(acc));
                end
        end
        for (int i = 0; i < 16; i++) begin
            e.element = 32'(view_m[i]);
            e.row     = 2'(i >> 2);
            e.col     = 2'(i & 3);
            e.last    = (i == 15);
            expected_elems.push_back(e);
        end
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_ang();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3)) << 14;
            1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_req make_req(logic [2:0] ops, logic [31:0] px, logic [31:0] py,
                                      logic [31:0] pz, logic [15:0] ax, logic [15:0] ay);
        t_req r;
        r.ops = ops; r.pos_x = px; r.pos_y = py; r.pos_z = pz;
        r.angle_x = ax; r.angle_y = ay;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else if (req_if.valid && !req_if.ready) begin
        end else begin
            if (req_if.valid) begin
                predict_matrix(req_if.data);
                n_sent <= n_sent + 1;
                if (req_if.data.ops & OP_ROT) n_rot <= n_rot + 1;
            end
            if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_off) begin
                req_if.valid <= 1'b1;
                req_if.data  <= pending_reqs.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor and output stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_cnt    <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_elems.size() == 0) begin
                    $display("%0t: unexpected element exp none act %h r%0d c%0d", $time,
                             rsp_if.data.element, rsp_if.data.row, rsp_if.data.col);
                    errors++;
                end else begin
                    if (rsp_if.data !== expected_elems[0]) begin
                        $display("%0t: element mismatch exp %h r%0d c%0d l%0b act %h r%0d c%0d l%0b",
                                 $time, expected_elems[0].element, expected_elems[0].row,
                                 expected_elems[0].col, expected_elems[0].last,
                                 rsp_if.data.element, rsp_if.data.row, rsp_if.data.col,
                                 rsp_if.data.last);
                        errors++;
                    end
                    void'(expected_elems.pop_front());
                    n_checked++;
                end
            end
            stall_cnt <= stall_cnt + 1;
            case (stall_cnt[9:8])
                2'd0:    rsp_if.ready <= 1'b1;
                2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
                2'd2:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_if.ready <= stall_cnt[2] | stall_cnt[4];
            endcase
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [2:0] op;
        i_clk = 1'b0;
        errors = 0; n_sent = 0; n_checked = 0; n_rot = 0; hold_off = 0;
        i_rst_n = 1'b0;
        load_ident();

        pending_reqs.push_back(make_req(3'b000, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_TRANS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0, 0));
        pending_reqs.push_back(make_req(OP_IDENT, 1, 2, 3, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'h4000, 16'hC000));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'h8000, 16'h8000));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'h4001, 16'hBFFF));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'hFFFF, 16'h0001));
        pending_reqs.push_back(make_req(3'b111, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                        16'h2000, 16'h6000));
        pending_reqs.push_back(make_req(OP_ROT, 0, 0, 0, 16'h2000, 16'h2000));
        pending_reqs.push_back(make_req(3'b011, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 0));
        pending_reqs.push_back(make_req(3'b110, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 16'h5555, 16'hAAAA));
        pending_reqs.push_back(make_req(3'b101, 0, 0, 0, 16'hC000, 16'h4000));
        pending_reqs.push_back(make_req(3'b111, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                        16'h7FFF, 16'h8001));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < 200; n++) begin
            op = 3'($urandom());
            if ($urandom_range(0, 9) == 0) op = OP_IDENT;
            pending_reqs.push_back(make_req(op, rand_pos(), rand_pos(), rand_pos(),
                                            rand_ang(), rand_ang()));
            if (n == 100) begin
                wait (pending_reqs.size() == 0);
                @(posedge i_clk);
                hold_off = 1'b1;
                wait (!req_if.valid && expected_elems.size() == 0);
                @(posedge i_clk);
                hold_off = 1'b0;
            end
        end

        wait (pending_reqs.size() == 0 && !req_if.valid);
        wait (expected_elems.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("sent %0d requests, %0d with rotation, checked %0d elements",
                 n_sent, n_rot, n_checked);
        if (errors == 0 && expected_elems.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
